// File: hw/rtl/lefr_pkg.sv
`default_nettype none

package lefr_pkg;

  localparam int LONG_STRIP_PIXELS = 16;
  localparam int RING_PIXELS       = 8;
  localparam int LEVEL_STEPS       = 5;
  localparam int BRIGHT_STEP       = 255 / LEVEL_STEPS;

  localparam int PIX_MAX = (LONG_STRIP_PIXELS > RING_PIXELS) ? LONG_STRIP_PIXELS : RING_PIXELS;
  localparam int PIX_W   = (PIX_MAX > 1) ? $clog2(PIX_MAX) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_ON         = 3'd4;

  localparam logic [7:0] EFF_FLASH        = 8'd1;
  localparam logic [7:0] EFF_FADE         = 8'd2;
  localparam logic [7:0] EFF_RAINBOW      = 8'd3;
  localparam logic [7:0] EFF_RAMP_FIRST   = 8'd4;
  localparam logic [7:0] EFF_RAMP_LAST    = 8'd7;
  localparam logic [7:0] EFF_BLINK_FIRST  = 8'd8;
  localparam logic [7:0] EFF_BLINK_YELLOW = 8'd10;
  localparam logic [7:0] EFF_BLINK_RED    = 8'd11;

  localparam logic [31:0] FLASH_MS      = 32'd300;
  localparam logic [31:0] FLASH_ON_MS   = 32'd100;
  localparam logic [31:0] FLASH_OFF_END = 32'd200;
  localparam logic [31:0] FADE_MS       = 32'd1000;
  localparam logic [31:0] FADE_HALF_MS  = 32'd500;
  localparam logic [9:0]  FADE_Q1_MS    = 10'd250;
  localparam logic [9:0]  FADE_Q2_MS    = 10'd500;
  localparam logic [9:0]  FADE_Q3_MS    = 10'd750;
  localparam logic [9:0]  FADE_Q4_MS    = 10'd1000;
  localparam logic [31:0] RAINBOW_MS    = 32'd500;
  localparam logic [31:0] RAMP_MS       = 32'd500;
  localparam logic [31:0] BLINK_MS      = 32'd600;
  localparam logic [31:0] BLINK_HALF_MS = 32'd300;

  // reciprocals: x/255 for x < 2^16, x/10 for x < 1024, x/500 for x < 2^18
  localparam logic [31:0] RECIP_255   = 32'd32897;
  localparam logic [16:0] RECIP_10    = 17'd205;
  localparam logic [34:0] RECIP_500   = 35'd134218;

  localparam logic [63:0] SINE_DIV_72 = 64'd72 * 64'd65536;
  localparam logic [63:0] SINE_DIV_42 = 64'd42 * 64'd65536;
  localparam logic [63:0] SINE_DIV_20 = 64'd20 * 64'd65536;
  localparam logic [63:0] SINE_DIV_6  = 64'd6 * 64'd65536;

  typedef struct packed {
    logic load_trig;
    logic load_frame;
    logic step_time;
    logic step_m1;
    logic step_m2;
    logic step_m3;
    logic step_m4;
    logic emit_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic no_emit;
    logic at_last;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef logic [16:0] sine_tab_t [0:255];

  function automatic logic [16:0] quarter_sine(input logic [7:0] x);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] s;
    a  = (64'(x) * 64'd102944 + 64'd125) / 64'd250;
    a2 = (a * a) >> 16;
    t  = 64'd65536;
    d  = (a2 * t) / SINE_DIV_72;
    t  = (d >= 64'd65536) ? 64'd0 : 64'd65536 - d;
    d  = (a2 * t) / SINE_DIV_42;
    t  = (d >= 64'd65536) ? 64'd0 : 64'd65536 - d;
    d  = (a2 * t) / SINE_DIV_20;
    t  = (d >= 64'd65536) ? 64'd0 : 64'd65536 - d;
    d  = (a2 * t) / SINE_DIV_6;
    t  = (d >= 64'd65536) ? 64'd0 : 64'd65536 - d;
    s  = (a * t) >> 16;
    return (s > 64'd65536) ? 17'h10000 : s[16:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    int i;
    for (i = 0; i < 256; i++) begin
      tab[i] = quarter_sine(8'(i));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  function automatic logic [7:0] pixel_offset(input logic strip, input logic [PIX_W-1:0] idx);
    logic [PIX_W+7:0] num;
    num = {idx, 8'd0};
    if (strip) begin
      return 8'(num / RING_PIXELS);
    end else begin
      return 8'(num / LONG_STRIP_PIXELS);
    end
  endfunction

  function automatic rgb_t wheel(input logic [7:0] pos);
    rgb_t c;
    logic [7:0] w;
    logic [7:0] v;
    w = 8'd255 - pos;
    if (w < 8'd85) begin
      v   = 8'(w * 8'd3);
      c.r = 8'd255 - v;
      c.g = 8'd0;
      c.b = v;
    end else if (w < 8'd170) begin
      v   = 8'((w - 8'd85) * 8'd3);
      c.r = 8'd0;
      c.g = v;
      c.b = 8'd255 - v;
    end else begin
      v   = 8'((w - 8'd170) * 8'd3);
      c.r = v;
      c.g = 8'd255 - v;
      c.b = 8'd0;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lefr_ctrl.sv
`default_nettype none

module lefr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_kind,
  output logic                  in_stall,
  output lefr_pkg::ctl_cmd_t    cmd,
  input  lefr_pkg::dp_status_t  status
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TIME = 7'b0000010,
    S_M1   = 7'b0000100,
    S_M2   = 7'b0001000,
    S_M3   = 7'b0010000,
    S_M4   = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind) begin
            cmd.load_frame = 1'b1;
            state_nxt      = S_TIME;
          end else begin
            cmd.load_trig = 1'b1;
          end
        end
      end
      S_TIME: begin
        cmd.step_time = 1'b1;
        state_nxt     = S_M1;
      end
      S_M1: begin
        cmd.step_m1 = 1'b1;
        state_nxt   = status.no_emit ? S_IDLE : S_M2;
      end
      S_M2: begin
        cmd.step_m2 = 1'b1;
        state_nxt   = S_M3;
      end
      S_M3: begin
        cmd.step_m3 = 1'b1;
        state_nxt   = S_M4;
      end
      S_M4: begin
        cmd.step_m4 = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.at_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lefr_datapath.sv
`default_nettype none

module lefr_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lefr_pkg::ctl_cmd_t                  cmd,
  output lefr_pkg::dp_status_t                status,
  input  logic                                cfg_wr_en,
  input  logic [lefr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lefr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [7:0]                          in_effect_code,
  input  logic [31:0]                         in_time_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_strip,
  output logic [3:0]                          out_pixel,
  output logic [7:0]                          out_red,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue,
  output logic                                out_last
);

  typedef enum logic [2:0] {
    SEL_SCALED,
    SEL_FADE,
    SEL_RAINBOW,
    SEL_RAMP,
    SEL_FIXED
  } sel_t;

  // configuration
  logic [7:0] color_r [3];
  logic [2:0] level_r;
  logic       light_on_r;

  // effect state
  logic        running_r;
  logic [7:0]  active_r;
  logic [31:0] start_r;

  // frame working registers
  logic [31:0] now_r;
  logic [31:0] e_r;
  logic [7:0]  bv_r;
  logic [15:0] p_r [3];
  logic [7:0]  q_r [3];
  logic [16:0] y_r [3];
  logic [16:0] sine_r;
  logic        fpos_r;
  logic [5:0]  e10_r;
  logic [8:0]  elo_r;
  sel_t        sel_r;
  logic        bl_red_r;
  logic        bl_green_r;
  logic [7:0]  fb_r;
  lefr_pkg::rgb_t col_r;

  // pixel walk
  logic                       strip_r;
  logic [lefr_pkg::PIX_W-1:0] pix_r;

  // output register
  logic       out_valid_r;
  logic       out_strip_r;
  logic [3:0] out_pixel_r;
  logic [7:0] out_red_r;
  logic [7:0] out_green_r;
  logic [7:0] out_blue_r;
  logic       out_last_r;

  // step one
  sel_t        sel_c;
  logic [7:0]  f_c;
  logic        win_c;
  logic        no_emit_c;
  logic        blink_on_c;
  logic [9:0]  ef_c;
  logic [7:0]  x_c;
  logic [16:0] e10_prod_c;
  logic [7:0]  lvl_c;

  // later steps
  logic [31:0] qprod_c [3];
  logic [17:0] fsum_c;
  logic [25:0] fprod_c;
  logic [34:0] rprod_c [3];
  logic [7:0]  ramp_c [3];

  // emit
  logic                at_last_c;
  logic                strip_end_c;
  logic [7:0]          wpos_c;
  lefr_pkg::rgb_t      wheel_c;
  lefr_pkg::rgb_t      pix_col_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r[0] <= 8'd255;
      color_r[1] <= 8'd255;
      color_r[2] <= 8'd255;
      level_r    <= 3'd0;
      light_on_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lefr_pkg::REG_COLOR_RED:        color_r[0] <= cfg_data;
        lefr_pkg::REG_COLOR_GREEN:      color_r[1] <= cfg_data;
        lefr_pkg::REG_COLOR_BLUE:       color_r[2] <= cfg_data;
        lefr_pkg::REG_BRIGHTNESS_LEVEL: level_r    <= cfg_data[2:0];
        lefr_pkg::REG_LIGHT_ON:         light_on_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sel_c      = SEL_SCALED;
    f_c        = light_on_r ? bv_r : 8'd0;
    win_c      = 1'b1;
    blink_on_c = (e_r < lefr_pkg::BLINK_HALF_MS);
    if (running_r) begin
      f_c = bv_r;
      priority if (active_r == lefr_pkg::EFF_FLASH) begin
        win_c = (e_r < lefr_pkg::FLASH_MS);
        if (!((e_r < lefr_pkg::FLASH_ON_MS) || (e_r >= lefr_pkg::FLASH_OFF_END))) begin
          f_c = 8'd0;
        end
      end else if (active_r == lefr_pkg::EFF_FADE) begin
        win_c = (e_r < lefr_pkg::FADE_MS);
        sel_c = SEL_FADE;
      end else if (active_r == lefr_pkg::EFF_RAINBOW) begin
        win_c = (e_r < lefr_pkg::RAINBOW_MS);
        sel_c = SEL_RAINBOW;
      end else if ((active_r >= lefr_pkg::EFF_RAMP_FIRST) &&
                   (active_r <= lefr_pkg::EFF_RAMP_LAST)) begin
        win_c = (e_r < lefr_pkg::RAMP_MS);
        sel_c = SEL_RAMP;
      end else if ((active_r >= lefr_pkg::EFF_BLINK_FIRST) &&
                   (active_r <= lefr_pkg::EFF_BLINK_RED)) begin
        win_c = (e_r < lefr_pkg::BLINK_MS);
        sel_c = SEL_FIXED;
      end else begin
        win_c = 1'b0;
      end
    end
    no_emit_c = running_r && !win_c;
  end

  // fold the fade time onto a quarter wave
  always_comb begin
    ef_c = e_r[9:0];
    if (ef_c <= lefr_pkg::FADE_Q1_MS) begin
      x_c = ef_c[7:0];
    end else if (ef_c < lefr_pkg::FADE_Q2_MS) begin
      x_c = 8'(lefr_pkg::FADE_Q2_MS - ef_c);
    end else if (ef_c <= lefr_pkg::FADE_Q3_MS) begin
      x_c = 8'(ef_c - lefr_pkg::FADE_Q2_MS);
    end else begin
      x_c = 8'(lefr_pkg::FADE_Q4_MS - ef_c);
    end
  end

  assign e10_prod_c = 17'(e_r[8:0]) * lefr_pkg::RECIP_10;
  assign lvl_c      = ({5'd0, level_r} > 8'(lefr_pkg::LEVEL_STEPS)) ?
                      8'(lefr_pkg::LEVEL_STEPS) : {5'd0, level_r};

  assign fsum_c  = fpos_r ? (18'd65536 + 18'(sine_r)) : (18'd65536 - 18'(sine_r));
  assign fprod_c = 26'(fsum_c) * 26'(bv_r);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qprod_c[k] = 32'(p_r[k]) * lefr_pkg::RECIP_255;
      rprod_c[k] = 35'(y_r[k]) * lefr_pkg::RECIP_500;
      ramp_c[k]  = rprod_c[k][33:26];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      active_r  <= 8'd0;
      start_r   <= 32'd0;
    end else if (cmd.load_trig) begin
      running_r <= 1'b1;
      active_r  <= in_effect_code;
      start_r   <= in_time_ms;
    end else if (cmd.step_m1 && no_emit_c) begin
      running_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      now_r <= in_time_ms;
    end
    if (cmd.step_time) begin
      e_r  <= now_r - start_r;
      bv_r <= 8'(lvl_c * 8'(lefr_pkg::BRIGHT_STEP));
    end
    if (cmd.step_m1) begin
      for (int k = 0; k < 3; k++) begin
        p_r[k] <= 16'(color_r[k]) * 16'(f_c);
      end
      sine_r     <= lefr_pkg::SINE_TAB[x_c];
      fpos_r     <= (e_r < lefr_pkg::FADE_HALF_MS);
      e10_r      <= e10_prod_c[16:11];
      elo_r      <= e_r[8:0];
      sel_r      <= sel_c;
      bl_red_r   <= blink_on_c && (active_r >= lefr_pkg::EFF_BLINK_YELLOW);
      bl_green_r <= blink_on_c && (active_r != lefr_pkg::EFF_BLINK_RED);
    end
    if (cmd.step_m2) begin
      for (int k = 0; k < 3; k++) begin
        q_r[k] <= qprod_c[k][30:23];
      end
      fb_r <= fprod_c[24:17];
    end
    if (cmd.step_m3) begin
      for (int k = 0; k < 3; k++) begin
        y_r[k] <= 17'(q_r[k]) * 17'(elo_r);
      end
    end
    if (cmd.step_m4) begin
      unique case (sel_r)
        SEL_RAMP:  col_r <= '{r: ramp_c[0], g: ramp_c[1], b: ramp_c[2]};
        SEL_FADE:  col_r <= '{r: 8'd0, g: 8'd0, b: fb_r};
        SEL_FIXED: col_r <= '{r: {8{bl_red_r}}, g: {8{bl_green_r}}, b: 8'd0};
        default:   col_r <= '{r: q_r[0], g: q_r[1], b: q_r[2]};
      endcase
    end
  end

  assign strip_end_c = (pix_r == lefr_pkg::PIX_W'(lefr_pkg::LONG_STRIP_PIXELS - 1));
  assign at_last_c   = strip_r && (pix_r == lefr_pkg::PIX_W'(lefr_pkg::RING_PIXELS - 1));
  assign wpos_c      = lefr_pkg::pixel_offset(strip_r, pix_r) + {2'b00, e10_r};
  assign wheel_c     = lefr_pkg::wheel(wpos_c);
  assign pix_col_c   = (sel_r == SEL_RAINBOW) ? wheel_c : col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_r <= 1'b0;
      pix_r   <= '0;
    end else if (cmd.load_frame) begin
      strip_r <= 1'b0;
      pix_r   <= '0;
    end else if (cmd.emit_load) begin
      if (!strip_r && strip_end_c) begin
        strip_r <= 1'b1;
        pix_r   <= '0;
      end else begin
        pix_r <= pix_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_strip_r <= strip_r;
      out_pixel_r <= 4'(pix_r);
      out_red_r   <= pix_col_c.r;
      out_green_r <= pix_col_c.g;
      out_blue_r  <= pix_col_c.b;
      out_last_r  <= at_last_c;
    end
  end

  assign status.no_emit  = no_emit_c;
  assign status.at_last  = at_last_c;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_strip = out_strip_r;
  assign out_pixel = out_pixel_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// File: hw/rtl/led_effect_frame_renderer.sv
`default_nettype none

// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// in       | in_valid / in_stall  | in_kind, in_effect_code, in_time_ms
// out      | out_valid / out_stall| out_strip, out_pixel, out_red/green/blue, out_last
// cfg      | cfg_wr_en            | cfg_index, cfg_data
//
// A frame item passes through a time-difference step and then a chain of four registered
// multiply steps, then emits one pixel per cycle while the output register is free; a
// running effect outside its window, or with an unknown code, emits no pixels and ends.
// Reset is synchronous, active low; it restores the register defaults and ends any effect.
// in_stall is high from a frame item until its last pixel sits in the output register;
// out_stall holds the output register and the pixel walk.

module led_effect_frame_renderer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [7:0]                          in_effect_code,
  input  logic [31:0]                         in_time_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_strip,
  output logic [3:0]                          out_pixel,
  output logic [7:0]                          out_red,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue,
  output logic                                out_last,
  input  logic                                cfg_wr_en,
  input  logic [lefr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lefr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lefr_pkg::ctl_cmd_t   cmd;
  lefr_pkg::dp_status_t status;

  lefr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  lefr_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_effect_code (in_effect_code),
    .in_time_ms     (in_time_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_strip      (out_strip),
    .out_pixel      (out_pixel),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

// File: tb/tb_led_effect_frame_renderer.sv
`timescale 1ns / 100ps

module tb_led_effect_frame_renderer;

  localparam logic KIND_TRIGGER = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;
  localparam int   FRAME_PIXELS = lefr_pkg::LONG_STRIP_PIXELS + lefr_pkg::RING_PIXELS;
  localparam int   DRAIN_CYCLES = 40;
  localparam int   HOLD_CYCLES  = 300;
  localparam int   CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic       strip;
    logic [3:0] pixel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_kind;
  logic [7:0]                      in_effect_code;
  logic [31:0]                     in_time_ms;
  logic                            out_valid;
  logic                            out_stall;
  logic                            out_strip;
  logic [3:0]                      out_pixel;
  logic [7:0]                      out_red;
  logic [7:0]                      out_green;
  logic [7:0]                      out_blue;
  logic                            out_last;
  logic                            cfg_wr_en;
  logic [lefr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [lefr_pkg::CFG_DATA_W-1:0] cfg_data;

  // shadow of the block's registers and effect state
  logic [7:0]  m_red;
  logic [7:0]  m_green;
  logic [7:0]  m_blue;
  logic [2:0]  m_level;
  logic        m_light;
  logic        fx_running;
  logic [7:0]  fx_code;
  logic [31:0] fx_start;

  pixel_t pending_pixels[$];

  int  errors;
  int  items_sent;
  int  frames_sent;
  int  pixels_checked;
  int  settings_used;
  int  cycle_count;
  bit  tx_idle;
  bit  rx_idle;
  bit  rx_hold;

  led_effect_frame_renderer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_effect_code (in_effect_code),
    .in_time_ms     (in_time_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_strip      (out_strip),
    .out_pixel      (out_pixel),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected", cycle_count,
               pending_pixels.size());
      $display("[led_effect_frame_renderer] ERROR");
      $finish;
    end
  end

  function automatic int unsigned level_value();
    int unsigned lv;
    lv = (m_level > lefr_pkg::LEVEL_STEPS) ? lefr_pkg::LEVEL_STEPS : m_level;
    return lv * lefr_pkg::BRIGHT_STEP;
  endfunction

  function automatic logic [7:0] scale_255(input logic [7:0] c, input int unsigned f);
    return 8'((c * f) / 255);
  endfunction

  function automatic longint unsigned sine_q16(input int unsigned x);
    int unsigned     div_tab [4] = '{72, 42, 20, 6};
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned quot;
    longint unsigned mag;
    ang    = (64'(x) * 64'd102944 + 64'd125) / 64'd250;
    ang_sq = (ang * ang) >> 16;
    term   = 65536;
    foreach (div_tab[k]) begin
      quot = (ang_sq * term) / (64'(div_tab[k]) * 64'd65536);
      term = (quot >= 65536) ? 0 : 65536 - quot;
    end
    mag = (ang * term) >> 16;
    return (mag > 65536) ? 65536 : mag;
  endfunction

  function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
    logic [7:0] w;
    w = 8'd255 - pos;
    if (w < 85) begin
      return {8'(255 - 3 * w), 8'd0, 8'(3 * w)};
    end else if (w < 170) begin
      return {8'd0, 8'(3 * (w - 85)), 8'(255 - 3 * (w - 85))};
    end
    return {8'(3 * (w - 170)), 8'(255 - 3 * (w - 170)), 8'd0};
  endfunction

  function automatic void push_frame(input bit rainbow, input int unsigned elapsed,
                                     input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b);
    int unsigned n;
    int unsigned count;
    pixel_t      px;
    logic [23:0] c;
    count = 0;
    for (int unsigned s = 0; s < 2; s++) begin
      n = (s == 0) ? lefr_pkg::LONG_STRIP_PIXELS : lefr_pkg::RING_PIXELS;
      for (int unsigned i = 0; i < n; i++) begin
        c = rainbow ? wheel_rgb(8'(i * 256 / n + elapsed / 10)) : {r, g, b};
        count++;
        px.strip = s[0];
        px.pixel = i[3:0];
        px.red   = c[23:16];
        px.green = c[15:8];
        px.blue  = c[7:0];
        px.last  = (count == FRAME_PIXELS);
        pending_pixels.push_back(px);
      end
    end
  endfunction

  function automatic void render_expected(input logic kind, input logic [7:0] code,
                                          input logic [31:0] t);
    int unsigned     bv;
    int unsigned     f;
    int unsigned     fold;
    logic [31:0]     e;
    longint unsigned level_sum;
    logic [7:0]      lit_r;
    logic [7:0]      lit_g;
    bv = level_value();
    if (kind == KIND_TRIGGER) begin
      fx_code    = code;
      fx_running = 1'b1;
      fx_start   = t;
      return;
    end
    if (!fx_running) begin
      if (m_light && bv > 0) begin
        push_frame(0, 0, scale_255(m_red, bv), scale_255(m_green, bv),
                   scale_255(m_blue, bv));
      end else begin
        push_frame(0, 0, 8'd0, 8'd0, 8'd0);
      end
      return;
    end
    e = t - fx_start;
    if (fx_code == lefr_pkg::EFF_FLASH && e < lefr_pkg::FLASH_MS) begin
      f = (e % lefr_pkg::FLASH_OFF_END < lefr_pkg::FLASH_ON_MS) ? bv : 0;
      push_frame(0, 0, scale_255(m_red, f), scale_255(m_green, f), scale_255(m_blue, f));
    end else if (fx_code == lefr_pkg::EFF_FADE && e < lefr_pkg::FADE_MS) begin
      if (e <= lefr_pkg::FADE_Q1_MS) begin
        fold = e;
      end else if (e < lefr_pkg::FADE_Q2_MS) begin
        fold = lefr_pkg::FADE_Q2_MS - e;
      end else if (e <= lefr_pkg::FADE_Q3_MS) begin
        fold = e - lefr_pkg::FADE_Q2_MS;
      end else begin
        fold = lefr_pkg::FADE_Q4_MS - e;
      end
      level_sum = (e < lefr_pkg::FADE_HALF_MS) ? 65536 + sine_q16(fold)
                                               : 65536 - sine_q16(fold);
      push_frame(0, 0, 8'd0, 8'd0, 8'((level_sum * bv) >> 17));
    end else if (fx_code == lefr_pkg::EFF_RAINBOW && e < lefr_pkg::RAINBOW_MS) begin
      push_frame(1, e, 8'd0, 8'd0, 8'd0);
    end else if (fx_code >= lefr_pkg::EFF_RAMP_FIRST && fx_code <= lefr_pkg::EFF_RAMP_LAST &&
                 e < lefr_pkg::RAMP_MS) begin
      push_frame(0, 0, 8'(scale_255(m_red, bv) * e / lefr_pkg::RAMP_MS),
                 8'(scale_255(m_green, bv) * e / lefr_pkg::RAMP_MS),
                 8'(scale_255(m_blue, bv) * e / lefr_pkg::RAMP_MS));
    end else if (fx_code >= lefr_pkg::EFF_BLINK_FIRST && fx_code <= lefr_pkg::EFF_BLINK_RED &&
                 e < lefr_pkg::BLINK_MS) begin
      lit_r = 8'd0;
      lit_g = 8'd0;
      if ((e / lefr_pkg::BLINK_HALF_MS) % 2 == 0) begin
        lit_r = (fx_code >= lefr_pkg::EFF_BLINK_YELLOW) ? 8'd255 : 8'd0;
        lit_g = (fx_code != lefr_pkg::EFF_BLINK_RED) ? 8'd255 : 8'd0;
      end
      push_frame(0, 0, lit_r, lit_g, 8'd0);
    end else begin
      fx_running = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("pixel %0d: %s is %0d, expected %0d", pixels_checked, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result, count", 1, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_strip !== want.strip) report_mismatch("strip", out_strip, want.strip);
        if (out_pixel !== want.pixel) report_mismatch("pixel", out_pixel, want.pixel);
        if (out_red !== want.red) report_mismatch("red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      end
      pixels_checked++;
    end
  end

  initial begin : drive_out_stall
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_stall <= 1'b1;
        for (int n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
        rx_hold = 1'b0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] code, input logic [31:0] t);
    int gap;
    gap = (tx_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_effect_code <= code;
    in_time_ms     <= t;
    do @(posedge clk); while (in_stall);
    render_expected(kind, code, t);
    items_sent++;
    if (kind == KIND_FRAME) frames_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lefr_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      lefr_pkg::REG_COLOR_RED:        m_red   = value;
      lefr_pkg::REG_COLOR_GREEN:      m_green = value;
      lefr_pkg::REG_COLOR_BLUE:       m_blue  = value;
      lefr_pkg::REG_BRIGHTNESS_LEVEL: m_level = value[2:0];
      lefr_pkg::REG_LIGHT_ON:         m_light = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic program_setting(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b, input logic [7:0] level,
                                 input logic [7:0] light);
    write_reg(lefr_pkg::REG_COLOR_RED, r);
    write_reg(lefr_pkg::REG_COLOR_GREEN, g);
    write_reg(lefr_pkg::REG_COLOR_BLUE, b);
    write_reg(lefr_pkg::REG_BRIGHTNESS_LEVEL, level);
    write_reg(lefr_pkg::REG_LIGHT_ON, light);
    settings_used++;
  endtask

  function automatic int unsigned effect_span(input logic [7:0] code);
    if (code == lefr_pkg::EFF_FLASH) return lefr_pkg::FLASH_MS;
    if (code == lefr_pkg::EFF_FADE) return lefr_pkg::FADE_MS;
    if (code == lefr_pkg::EFF_RAINBOW) return lefr_pkg::RAINBOW_MS;
    if (code >= lefr_pkg::EFF_RAMP_FIRST && code <= lefr_pkg::EFF_RAMP_LAST) begin
      return lefr_pkg::RAMP_MS;
    end
    if (code >= lefr_pkg::EFF_BLINK_FIRST && code <= lefr_pkg::EFF_BLINK_RED) begin
      return lefr_pkg::BLINK_MS;
    end
    return 10;
  endfunction

  task automatic run_random(input int count);
    int          target;
    int unsigned span;
    logic [7:0]  code;
    logic [31:0] start;
    logic [31:0] e;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) < 8) begin
        code  = ($urandom_range(0, 15) < 13) ? 8'($urandom_range(1, 11)) : 8'($urandom);
        start = $urandom;
        span  = effect_span(code);
        send_item(KIND_TRIGGER, code, start);
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(0, 5))
            0:       e = span + $urandom_range(0, 3);
            1:       e = span - 1;
            default: e = $urandom_range(0, span - 1);
          endcase
          send_item(KIND_FRAME, code, start + e);
        end
      end else begin
        send_item(1'($urandom), 8'($urandom), $urandom);
      end
    end
  endtask

  task automatic test_idle_frames();
    send_item(KIND_FRAME, 8'd0, 32'd0);
    wait_drained();
    program_setting(8'd255, 8'd255, 8'd255, 8'd5, 8'd1);
    send_item(KIND_FRAME, 8'hFF, 32'hFFFF_FFFF);
    wait_drained();
    program_setting(8'd17, 8'd200, 8'd0, 8'd7, 8'd0);
    send_item(KIND_FRAME, 8'd0, 32'h8000_0000);
    wait_drained();
    write_reg(lefr_pkg::REG_LIGHT_ON, 8'd1);
    send_item(KIND_FRAME, 8'd0, 32'h0000_1234);
    wait_drained();
  endtask

  task automatic test_effects_directed();
    program_setting(8'd200, 8'd100, 8'd50, 8'd5, 8'd1);
    send_item(KIND_TRIGGER, lefr_pkg::EFF_FLASH, 32'd1000);
    send_item(KIND_FRAME, 8'd0, 32'd1000);
    send_item(KIND_FRAME, 8'd0, 32'd1150);
    send_item(KIND_FRAME, 8'd0, 32'd1300);
    send_item(KIND_TRIGGER, lefr_pkg::EFF_FADE, 32'd0);
    send_item(KIND_FRAME, 8'd0, 32'd250);
    send_item(KIND_FRAME, 8'd0, 32'd750);
    send_item(KIND_FRAME, 8'd0, 32'd1000);
    // start just below the wrap of the millisecond counter
    send_item(KIND_TRIGGER, lefr_pkg::EFF_RAINBOW, 32'hFFFF_FFF0);
    send_item(KIND_FRAME, 8'd0, 32'h0000_01E0);
    send_item(KIND_FRAME, 8'd0, 32'h0000_01E4);
    send_item(KIND_TRIGGER, lefr_pkg::EFF_RAMP_LAST, 32'd5000);
    send_item(KIND_FRAME, 8'd0, 32'd5499);
    send_item(KIND_TRIGGER, lefr_pkg::EFF_BLINK_YELLOW, 32'd7000);
    send_item(KIND_FRAME, 8'd0, 32'd7000);
    send_item(KIND_TRIGGER, lefr_pkg::EFF_BLINK_RED, 32'd8000);
    send_item(KIND_FRAME, 8'd0, 32'd8300);
    send_item(KIND_TRIGGER, 8'd0, 32'd9000);
    send_item(KIND_FRAME, 8'd0, 32'd9000);
    send_item(KIND_TRIGGER, 8'hFF, 32'd9100);
    send_item(KIND_FRAME, 8'd0, 32'd9100);
    wait_drained();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       program_setting(8'd0, 8'd0, 8'd0, 8'd5, 8'd1);
        1:       program_setting(8'd255, 8'd255, 8'd255, 8'd7, 8'd0);
        2:       program_setting(8'd255, 8'd0, 8'd255, 8'd1, 8'd1);
        default: program_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom));
      endcase
      run_random(50);
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    program_setting(8'd90, 8'd180, 8'd255, 8'd4, 8'd1);
    send_item(KIND_TRIGGER, lefr_pkg::EFF_RAMP_FIRST, 32'd20000);
    rx_hold = 1'b1;
    for (int k = 0; k < 5; k++) begin
      send_item(KIND_FRAME, 8'd0, 32'd20000 + 100 * k);
    end
    wait_drained();
  endtask

  task automatic test_final_no_idle();
    program_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'd5, 8'd1);
    run_random(30);
    wait_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_TRIGGER;
    in_effect_code = 8'd0;
    in_time_ms     = 32'd0;
    cfg_wr_en      = 1'b0;
    cfg_index      = lefr_pkg::REG_COLOR_RED;
    cfg_data       = 8'd0;
    m_red          = 8'd255;
    m_green        = 8'd255;
    m_blue         = 8'd255;
    m_level        = 3'd0;
    m_light        = 1'b1;
    fx_running     = 1'b0;
    fx_code        = 8'd0;
    fx_start       = 32'd0;
    tx_idle        = 1'b1;
    rx_idle        = 1'b1;
    rx_hold        = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_frames();
    test_effects_directed();
    test_random_phases();
    test_backpressure();
    test_final_no_idle();

    $display("%0d items sent (%0d frames), %0d pixels compared", items_sent, frames_sent,
             pixels_checked);
    $display("%0d register settings, every effect code plus unknown codes and expiry",
             settings_used);
    if (errors == 0) begin
      $display("[led_effect_frame_renderer] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[led_effect_frame_renderer] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lefr_pkg.sv
hw/rtl/lefr_ctrl.sv
hw/rtl/lefr_datapath.sv
hw/rtl/led_effect_frame_renderer.sv
tb/tb_led_effect_frame_renderer.sv
